@@ hw/rtl/ordered_list_engine_assert.svh @@
// Assertion macros for the ordered list engine.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset
`define OLE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define OLE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OLE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define OLE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

@@ hw/rtl/ole_pkg.sv @@
// Shared types and constants for the ordered list engine.
// No dependencies; imported by ole_cell and ordered_list_engine.
`default_nettype none

package ole_pkg;

  // Default list depth
  localparam int DEPTH_DEFAULT = 16;

  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  localparam int SUM_W = 36;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_BAD_POS = 2'd2,
    ERR_EMPTY   = 2'd3
  } err_t;

  // Input item
  typedef struct packed {
    mode_t              mode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_t;

  // Result item
  typedef struct packed {
    logic                    found;
    logic [3:0]              found_index;
    logic [4:0]              entry_total;
    logic signed [31:0]      smallest;
    logic signed [31:0]      largest;
    logic signed [SUM_W-1:0] total_sum;
    err_t                    error_code;
  } rsp_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic               shift_en;
    logic               insert;
    logic signed [31:0] value;
  } ctl_t;

  // Partial reduction handed from cell to cell
  typedef struct packed {
    logic                    found;
    logic signed [31:0]      smallest;
    logic signed [31:0]      largest;
    logic signed [SUM_W-1:0] total_sum;
  } scan_t;

endpackage

`default_nettype wire

@@ hw/rtl/ordered_list_engine.sv @@
// Channel  Signals                       Dir  Payload
// req      req_valid, req_ready, req     in   req_t: mode, position, value
// rsp      rsp_valid, rsp_ready, rsp     out  rsp_t: search hit, count, min, max, sum, error
//
// req_ready stays low from the accepting edge until the item's result is loaded,
// so no new item is taken before the last is through: the accepting edge shifts
// the cell chain, the partial min/max/sum and search result ripple one cell per
// cycle to the end of the chain, and a last edge loads the result register.
// Reset (synchronous, active high) empties the list; stored entries are not cleared.
// A held result does not block the next item; the chain waits at its end
// only if the previous result has still not been taken.
// Top level of the ordered list engine; uses ole_pkg, ole_cell and
// ordered_list_engine_assert.svh.
`default_nettype none

`include "ordered_list_engine_assert.svh"

module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int POS_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   scan_cnt;
  logic [CNT_W-1:0]   scan_cnt_next;
  mode_t              item_mode;
  err_t               item_err;
  logic signed [31:0] search_value;

  logic               accept;
  logic               load;
  err_t               err;
  logic [POS_W-1:0]   pos_ext;
  logic [POS_W-1:0]   count_ext;
  ctl_t               ctl;

  logic signed [31:0] data_q [DEPTH];
  scan_t              scan_q [DEPTH];
  logic [IDX_W-1:0]   idx_q  [DEPTH];
  scan_t              scan_seed;

  logic [IDX_W+3:0]   idx_wide;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign load      = (state == ST_SCAN) && (scan_cnt == '0) && (!rsp_valid || rsp_ready);

  assign pos_ext   = POS_W'(req.position);
  assign count_ext = POS_W'(count);

  // Error check on the incoming item against the current count
  always_comb begin
    err = ERR_OK;
    unique case (req.mode)
      MODE_INSERT: begin
        priority if (count_ext >= DEPTH_P) begin
          err = ERR_FULL;
        end else if (pos_ext > count_ext) begin
          err = ERR_BAD_POS;
        end else begin
          err = ERR_OK;
        end
      end
      MODE_REMOVE: begin
        priority if (count_ext == '0) begin
          err = ERR_EMPTY;
        end else if (pos_ext >= count_ext) begin
          err = ERR_BAD_POS;
        end else begin
          err = ERR_OK;
        end
      end
      default: err = ERR_OK;
    endcase
  end

  // Shift command for the chain, applied at the accepting edge
  always_comb begin
    ctl.shift_en = accept && (err == ERR_OK) &&
                   ((req.mode == MODE_INSERT) || (req.mode == MODE_REMOVE));
    ctl.insert   = (req.mode == MODE_INSERT);
    ctl.value    = req.value;
  end

  // Count update
  always_comb begin
    count_next = count;
    if (accept && (err == ERR_OK)) begin
      unique case (req.mode)
        MODE_INSERT: count_next = count + CNT_W'(1);
        MODE_REMOVE: count_next = count - CNT_W'(1);
        MODE_CLEAR:  count_next = '0;
        default:     count_next = count;
      endcase
    end
  end

  // Sequencer: idle, then wait for the partial to reach the end of the chain and for the result register to be free
  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next    = ST_SCAN;
          scan_cnt_next = CNT_W'(DEPTH);
        end
      end
      ST_SCAN: begin
        if (scan_cnt != '0) begin
          scan_cnt_next = scan_cnt - CNT_W'(1);
        end else if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next    = ST_IDLE;
        scan_cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
    end
  end

  // Per-item context
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode    <= req.mode;
      item_err     <= err;
      search_value <= req.value;
    end
  end

  // Cell chain
  always_comb begin
    scan_seed.found     = 1'b0;
    scan_seed.smallest  = INT_MAX;
    scan_seed.largest   = INT_MIN;
    scan_seed.total_sum = '0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;
    scan_t              s_in;
    logic [IDX_W-1:0]   i_in;

    if (i == 0) begin : g_first
      assign left_d = ctl.value;
      assign s_in   = scan_seed;
      assign i_in   = '0;
    end else begin : g_mid
      assign left_d = data_q[i-1];
      assign s_in   = scan_q[i-1];
      assign i_in   = idx_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = data_q[i];
    end else begin : g_inner
      assign right_d = data_q[i+1];
    end

    ole_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .POS_W (POS_W)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .pos          (pos_ext),
      .count        (count_ext),
      .search_value (search_value),
      .left_data    (left_d),
      .right_data   (right_d),
      .data         (data_q[i]),
      .scan_in      (s_in),
      .idx_in       (i_in),
      .scan_out     (scan_q[i]),
      .idx_out      (idx_q[i])
    );
  end

  // Result register
  assign idx_wide = {4'b0000, idx_q[DEPTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.found       <= (item_mode == MODE_SEARCH) && scan_q[DEPTH-1].found;
      rsp.found_index <= (item_mode == MODE_SEARCH) ? idx_wide[3:0] : 4'd0;
      rsp.entry_total <= count_ext[4:0];
      rsp.smallest    <= scan_q[DEPTH-1].smallest;
      rsp.largest     <= scan_q[DEPTH-1].largest;
      rsp.total_sum   <= scan_q[DEPTH-1].total_sum;
      rsp.error_code  <= item_err;
    end
  end

  // Checks
  `OLE_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, count_ext <= DEPTH_P, "list count above depth")
  `OLE_ASSERT_NXT(a_err_keeps_count, clk, rst, accept && (err != ERR_OK), count == $past(count), "failed item changed the count")
  `OLE_ASSERT_IMP(a_count_stable_scan, clk, rst, (state == ST_SCAN) && $past(state == ST_SCAN), $stable(count), "count moved during scan")
  `OLE_ASSERT_IMP(a_result_after_scan, clk, rst, $rose(rsp_valid), $past((state == ST_SCAN) && (scan_cnt == '0)), "result issued before scan end")

endmodule

`default_nettype wire

@@ hw/rtl/ole_cell.sv @@
// One list slot: holds an entry, shifts with its neighbors, and adds its
// entry to the min/max/sum/search partial passed along the chain. Uses ole_pkg.
`default_nettype none

module ole_cell
  import ole_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = $clog2(DEPTH_DEFAULT),
  parameter int POS_W = 5
) (
  input  wire logic               clk,
  input  wire ctl_t               ctl,
  input  wire logic [POS_W-1:0]   pos,
  input  wire logic [POS_W-1:0]   count,
  input  wire logic signed [31:0] search_value,
  input  wire logic signed [31:0] left_data,
  input  wire logic signed [31:0] right_data,
  output logic signed [31:0]      data,
  input  wire scan_t              scan_in,
  input  wire logic [IDX_W-1:0]   idx_in,
  output scan_t                   scan_out,
  output logic [IDX_W-1:0]        idx_out
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                  live;
  scan_t                 scan_next;
  logic [IDX_W-1:0]      idx_next;

  // Entry storage: insert opens a gap at pos, remove closes it
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      if (ctl.insert) begin
        if (MY_POS == pos) begin
          data <= ctl.value;
        end else if (MY_POS > pos) begin
          data <= left_data;
        end
      end else if (MY_POS >= pos) begin
        data <= right_data;
      end
    end
  end

  assign live = (MY_POS < count);

  // Fold this entry into the partial from the left
  always_comb begin
    scan_next = scan_in;
    idx_next  = idx_in;
    if (live) begin
      if ($signed(data) < $signed(scan_in.smallest)) begin
        scan_next.smallest = data;
      end
      if ($signed(data) > $signed(scan_in.largest)) begin
        scan_next.largest = data;
      end
      scan_next.total_sum = scan_in.total_sum + SUM_W'(data);
      if (!scan_in.found && (data == search_value)) begin
        scan_next.found = 1'b1;
        idx_next        = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    idx_out  <= idx_next;
  end

endmodule

`default_nettype wire

@@ dv/ordered_list_engine_tb.sv @@
// Self-checking testbench for ordered_list_engine: insert, remove, search and clear items.
// Predicts every result from a list model of its own; needs ole_pkg and the engine RTL.
`default_nettype none

module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam int HALF_CYCLE = 2;
  localparam int ITEM_CYCLES = LIST_DEPTH + 2;
  localparam int RUN_LIMIT = 4 * 800000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  ordered_list_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #(HALF_CYCLE) clk = ~clk;

  // List model: contents and live count after every accepted item
  logic signed [31:0] list_model [LIST_DEPTH];
  int unsigned live_entries = 0;

  rsp_t pending_results [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int mode_count [4] = '{default: 0};
  int error_count [4] = '{default: 0};
  int search_hits = 0;

  // Apply one item to the list model and return the result it should produce
  function automatic rsp_t apply_list_op(req_t item);
    rsp_t r;
    logic signed [SUM_W-1:0] acc;
    int i;
    r = '0;
    r.error_code = ERR_OK;
    case (item.mode)
      MODE_INSERT: begin
        if (live_entries >= LIST_DEPTH) begin
          r.error_code = ERR_FULL;
        end else if (item.position > live_entries) begin
          r.error_code = ERR_BAD_POS;
        end else begin
          for (i = live_entries; i > item.position; i--) list_model[i] = list_model[i-1];
          list_model[item.position] = item.value;
          live_entries++;
        end
      end
      MODE_REMOVE: begin
        if (live_entries == 0) begin
          r.error_code = ERR_EMPTY;
        end else if (item.position >= live_entries) begin
          r.error_code = ERR_BAD_POS;
        end else begin
          for (i = item.position; i + 1 < live_entries; i++) list_model[i] = list_model[i+1];
          live_entries--;
        end
      end
      MODE_SEARCH: begin
        for (i = 0; i < live_entries; i++) begin
          if (list_model[i] == item.value) begin
            r.found = 1'b1;
            r.found_index = i[3:0];
            break;
          end
        end
      end
      default: begin
        live_entries = 0;
      end
    endcase
    // Min, max and sum over the live entries
    r.smallest = INT_MAX;
    r.largest = INT_MIN;
    acc = '0;
    for (i = 0; i < live_entries; i++) begin
      if (list_model[i] < r.smallest) r.smallest = list_model[i];
      if (list_model[i] > r.largest) r.largest = list_model[i];
      acc = acc + list_model[i];
    end
    r.total_sum = acc;
    r.entry_total = live_entries[4:0];
    return r;
  endfunction

  function automatic req_t make_op(mode_t m, int unsigned p, logic signed [31:0] v);
    req_t item;
    item.mode = m;
    item.position = p[4:0];
    item.value = v;
    return item;
  endfunction

  // Values biased toward extremes and small repeats so searches hit
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return INT_MAX;
      1: return INT_MIN;
      2: return -32'sd1;
      3, 4: return $signed($urandom_range(6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed items against the current list, some noise
  function automatic req_t pick_list_op();
    int roll;
    logic signed [31:0] v;
    roll = $urandom_range(99);
    if (roll < 45) begin
      return make_op(MODE_INSERT, $urandom_range(live_entries), pick_value());
    end else if (roll < 72) begin
      return make_op(MODE_REMOVE,
                     live_entries == 0 ? 0 : $urandom_range(live_entries - 1), pick_value());
    end else if (roll < 90) begin
      v = pick_value();
      if (live_entries > 0 && $urandom_range(99) < 60)
        v = list_model[$urandom_range(live_entries - 1)];
      return make_op(MODE_SEARCH, $urandom_range(31), v);
    end else if (roll < 93) begin
      return make_op(MODE_CLEAR, $urandom_range(31), $urandom);
    end
    return make_op(mode_t'($urandom_range(3)), $urandom_range(31), $urandom);
  endfunction

  // Offer one item, wait for acceptance, record its expected result
  task automatic send_op(req_t item);
    rsp_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    want = apply_list_op(item);
    pending_results.push_back(want);
    mode_count[item.mode]++;
    error_count[want.error_code]++;
    if (want.found) search_hits++;
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_results_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extremes of every field, each error and each empty/full case
  task automatic test_directed();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_op(make_op(MODE_REMOVE, 0, 0));              // remove from empty list
    send_op(make_op(MODE_SEARCH, 0, 0));              // search in empty list
    send_op(make_op(MODE_INSERT, 16, 1));             // insert past count
    send_op(make_op(MODE_CLEAR, 31, -32'sd1));        // clear an empty list
    for (k = 0; k < LIST_DEPTH - 1; k++) send_op(make_op(MODE_INSERT, 0, INT_MIN));
    send_op(make_op(MODE_INSERT, 7, INT_MAX));        // fills the list
    send_op(make_op(MODE_INSERT, 31, 5));             // full wins over bad position
    send_op(make_op(MODE_SEARCH, 0, INT_MIN));        // lowest of many matches
    send_op(make_op(MODE_SEARCH, 31, INT_MAX));
    send_op(make_op(MODE_SEARCH, 0, -32'sd1));        // not present
    send_op(make_op(MODE_REMOVE, 16, 0));             // position equal to count
    send_op(make_op(MODE_REMOVE, LIST_DEPTH - 1, 0)); // remove last entry
    send_op(make_op(MODE_INSERT, LIST_DEPTH - 1, -32'sd1)); // append
    send_op(make_op(MODE_CLEAR, 0, 0));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
    int k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (k = 0; k < n_items; k++) send_op(pick_list_op());
    wait_results_drained();
  endtask

  // Receiver holds off long enough that the engine backs up into its input
  task automatic test_output_stall();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    for (k = 0; k < 12; k++) send_op(pick_list_op());
    wait_results_drained();
  endtask

  // Receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result item: %p", rsp);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (rsp.found !== want.found || rsp.found_index !== want.found_index ||
            rsp.entry_total !== want.entry_total || rsp.smallest !== want.smallest ||
            rsp.largest !== want.largest || rsp.total_sum !== want.total_sum ||
            rsp.error_code !== want.error_code) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d: expected found=%0b idx=%0d count=%0d min=%0d max=%0d sum=%0d err=%0d",
                     results_checked, want.found, want.found_index, want.entry_total,
                     want.smallest, want.largest, want.total_sum, want.error_code);
            $display("result %0d: actual   found=%0b idx=%0d count=%0d min=%0d max=%0d sum=%0d err=%0d",
                     results_checked, rsp.found, rsp.found_index, rsp.entry_total,
                     rsp.smallest, rsp.largest, rsp.total_sum, rsp.error_code);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(400, 20, 81);
    test_output_stall();
    test_random_traffic(400, 81, 20);
    test_random_traffic(400, 0, 0);

    // Catch any stray result after the last expected one
    repeat (ITEM_CYCLES * 2) @(posedge clk);

    $display("checked %0d results: %0d inserts, %0d removes, %0d searches (%0d hits), %0d clears",
             results_checked, mode_count[MODE_INSERT], mode_count[MODE_REMOVE],
             mode_count[MODE_SEARCH], search_hits, mode_count[MODE_CLEAR]);
    $display("errors predicted: %0d list full, %0d bad position, %0d list empty",
             error_count[ERR_FULL], error_count[ERR_BAD_POS], error_count[ERR_EMPTY]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("watchdog expired with %0d results outstanding", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ole_pkg.sv
hw/rtl/ole_cell.sv
hw/rtl/ordered_list_engine.sv
dv/ordered_list_engine_tb.sv
